### hdl/delta_time_event_queue_top_assert.svh
// Assertion macros shared by the delta time event queue modules.
// Each macro needs clk in the caller; DTEQ_ASSERT also needs rst_n.
// Defining ASSERT_OFF removes every assertion.
`ifndef DELTA_TIME_EVENT_QUEUE_TOP_ASSERT_SVH
`define DELTA_TIME_EVENT_QUEUE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define DTEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DTEQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTEQ_ASSERT(label, prop, msg)
`define DTEQ_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### hdl/dteq_pkg.sv
// Package for the delta time event queue: opcodes, controller states and
// the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package dteq_pkg;

    localparam int DELTA_W     = 32;
    localparam int TASK_W      = 8;
    localparam int STEP_W      = 24;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_POP     = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_STEP,
        S_POP_READ,
        S_POP_CHECK,
        S_WALK,
        S_TAIL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic latch;
        logic clear_all;
        logic add_step;
        logic rd_front;
        logic pop_check;
        logic walk;
        logic tail;
        logic drop;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
        logic walk_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

### hdl/dteq_if.sv
// Valid/ready channel interfaces for the delta time event queue:
// the request channel and the result channel.
// No dependencies.
`default_nettype none

interface dteq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  task_id;
    logic [31:0] delay;
    logic [23:0] time_step;

    modport source (output valid, output opcode, output task_id, output delay,
                    output time_step, input ready);
    modport sink   (input valid, input opcode, input task_id, input delay,
                    input time_step, output ready);
endinterface

interface dteq_out_if;
    logic       valid;
    logic       ready;
    logic       task_valid;
    logic [7:0] due_task;
    logic       insert_dropped;
    logic [4:0] entry_count;

    modport source (output valid, output task_valid, output due_task,
                    output insert_dropped, output entry_count, input ready);
    modport sink   (input valid, input task_valid, input due_task,
                    input insert_dropped, input entry_count, output ready);
endinterface

`default_nettype wire

### hdl/dteq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module dteq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/dteq_ctrl.sv
// Controller state machine of the delta time event queue.
// Depends on dteq_pkg and the assertion macro header.
`default_nettype none
`include "delta_time_event_queue_top_assert.svh"

module dteq_ctrl
    import dteq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output      logic    in_ready,
    input  wire status_t st,
    output      cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (st.op)
                    OP_INSERT:
                    begin
                        if (st.full)
                        begin
                            cmd.drop   = 1'b1;
                            state_next = S_DONE;
                        end
                        else if (st.empty)
                        begin
                            state_next = S_TAIL;
                        end
                        else
                        begin
                            cmd.rd_front = 1'b1;
                            state_next   = S_WALK;
                        end
                    end
                    OP_ADVANCE: state_next = S_STEP;
                    OP_POP:     state_next = S_POP_READ;
                    OP_CLEAR:
                    begin
                        cmd.clear_all = 1'b1;
                        state_next    = S_DONE;
                    end
                    default:    state_next = S_DONE;
                endcase
            end
            S_STEP:
            begin
                cmd.add_step = 1'b1;
                state_next   = S_POP_READ;
            end
            S_POP_READ:
            begin
                cmd.rd_front = 1'b1;
                state_next   = S_POP_CHECK;
            end
            S_POP_CHECK:
            begin
                cmd.pop_check = 1'b1;
                state_next    = S_DONE;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (st.walk_last)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                cmd.tail   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    `DTEQ_ASSERT(a_load_needs_room, cmd.load_out |-> st.out_free, "result loaded over a held beat")
    `DTEQ_ASSERT(a_accept_decodes, (in_valid && in_ready) |=> (state_reg == S_DECODE), "accepted beat not decoded")
    `DTEQ_ASSERT(a_walk_nonempty, (state_reg == S_WALK) |-> !st.empty, "walk over an empty queue")

endmodule

`default_nettype wire

### hdl/dteq_datapath.sv
// Datapath of the delta time event queue: item registers, circular entry
// store in RAM, elapsed counter and result register.
// Depends on dteq_pkg, dteq_ram and the assertion macro header.
`default_nettype none
`include "delta_time_event_queue_top_assert.svh"

module dteq_datapath
    import dteq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmd_t                   cmd,
    output      status_t                st,
    input  wire logic [1:0]             opcode,
    input  wire logic [TASK_W-1:0]      task_id,
    input  wire logic [DELTA_W-1:0]     delay,
    input  wire logic [STEP_W-1:0]      time_step,
    output      logic                   out_valid,
    input  wire logic                   out_ready,
    output      logic                   task_valid,
    output      logic [TASK_W-1:0]      due_task,
    output      logic                   insert_dropped,
    output      logic [COUNT_OUT_W-1:0] entry_count
);

    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int AW    = CW + 1;
    localparam int EW    = DELTA_W + TASK_W;
    localparam int CNT_W = 32 + FRACTION_BITS;

    // Physical slot of the entry at a position counted from the front.
    function automatic logic [PW-1:0] wrap_addr(logic [PW-1:0] base, logic [CW-1:0] rel);
        logic [AW-1:0] s;
        s = AW'(base) + AW'(rel);
        if (s >= AW'(QUEUE_DEPTH))
        begin
            s = s - AW'(QUEUE_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    op_t                 op_reg;
    logic [TASK_W-1:0]   id_reg;
    logic [DELTA_W-1:0]  rem_reg,     rem_next;
    logic [STEP_W-1:0]   step_reg;
    logic [CW-1:0]       count_reg,   count_next;
    logic [PW-1:0]       head_reg,    head_next;
    logic [CNT_W-1:0]    counter_reg, counter_next;
    logic [CW-1:0]       idx_reg,     idx_next;
    logic                placed_reg,  placed_next;
    logic [EW-1:0]       carry_reg,   carry_next;
    logic                res_valid_reg, res_valid_next;
    logic [TASK_W-1:0]   res_task_reg,  res_task_next;
    logic                res_drop_reg,  res_drop_next;
    logic                out_valid_reg;
    logic                out_task_valid_reg;
    logic [TASK_W-1:0]   out_task_reg;
    logic                out_drop_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;

    logic                we;
    logic [PW-1:0]       waddr;
    logic [EW-1:0]       wdata;
    logic                re;
    logic [PW-1:0]       raddr;
    logic [EW-1:0]       rdata;
    logic [DELTA_W-1:0]  rd_delta;
    logic [TASK_W-1:0]   rd_task;
    logic [CNT_W-1:0]    front;
    logic [CNT_W:0]      step_sum;
    logic                pop_hit;

    assign rd_delta = rdata[EW-1:TASK_W];
    assign rd_task  = rdata[TASK_W-1:0];
    assign front    = CNT_W'(rd_delta) << FRACTION_BITS;
    assign pop_hit  = counter_reg > front;
    assign step_sum = {1'b0, counter_reg} + (CNT_W + 1)'(step_reg);

    // During the walk the next entry is fetched while the current one is handled.
    assign re    = cmd.rd_front || cmd.walk;
    assign raddr = wrap_addr(head_reg, cmd.walk ? (idx_reg + CW'(1)) : CW'(0));

    dteq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        rem_next       = rem_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        counter_next   = counter_reg;
        idx_next       = idx_reg;
        placed_next    = placed_reg;
        carry_next     = carry_reg;
        res_valid_next = res_valid_reg;
        res_task_next  = res_task_reg;
        res_drop_next  = res_drop_reg;
        we             = 1'b0;
        waddr          = wrap_addr(head_reg, idx_reg);
        wdata          = carry_reg;

        if (cmd.latch)
        begin
            rem_next       = delay;
            idx_next       = '0;
            placed_next    = 1'b0;
            res_valid_next = 1'b0;
            res_task_next  = '0;
            res_drop_next  = 1'b0;
        end

        if (cmd.clear_all)
        begin
            count_next   = '0;
            head_next    = '0;
            counter_next = '0;
        end

        if (cmd.drop)
        begin
            res_drop_next = 1'b1;
        end

        if (cmd.add_step)
        begin
            counter_next = step_sum[CNT_W] ? {CNT_W{1'b1}} : step_sum[CNT_W-1:0];
        end

        if (cmd.pop_check)
        begin
            if (count_reg == '0)
            begin
                counter_next = '0;
            end
            else if (pop_hit)
            begin
                counter_next   = counter_reg - front;
                res_valid_next = 1'b1;
                res_task_next  = rd_task;
                head_next      = wrap_addr(head_reg, CW'(1));
                count_next     = count_reg - CW'(1);
            end
        end

        if (cmd.walk)
        begin
            idx_next = idx_reg + CW'(1);
            if (!placed_reg)
            begin
                if (rem_reg > rd_delta)
                begin
                    rem_next = rem_reg - rd_delta;
                end
                else
                begin
                    // New entry takes this slot; the old entry moves back one.
                    we          = 1'b1;
                    wdata       = {rem_reg, id_reg};
                    carry_next  = {rd_delta - rem_reg, rd_task};
                    placed_next = 1'b1;
                end
            end
            else
            begin
                we         = 1'b1;
                wdata      = carry_reg;
                carry_next = rdata;
            end
        end

        if (cmd.tail)
        begin
            we         = 1'b1;
            waddr      = wrap_addr(head_reg, count_reg);
            wdata      = placed_reg ? carry_reg : {rem_reg, id_reg};
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            counter_reg   <= '0;
            idx_reg       <= '0;
            placed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            head_reg    <= head_next;
            counter_reg <= counter_next;
            idx_reg     <= idx_next;
            placed_reg  <= placed_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= op_t'(opcode);
            id_reg   <= task_id;
            step_reg <= time_step;
        end
        rem_reg       <= rem_next;
        carry_reg     <= carry_next;
        res_valid_reg <= res_valid_next;
        res_task_reg  <= res_task_next;
        res_drop_reg  <= res_drop_next;
        if (cmd.load_out)
        begin
            out_task_valid_reg <= res_valid_reg;
            out_task_reg       <= res_task_reg;
            out_drop_reg       <= res_drop_reg;
            out_count_reg      <= COUNT_OUT_W'(count_reg);
        end
    end

    assign st.op        = op_reg;
    assign st.empty     = (count_reg == '0);
    assign st.full      = (count_reg >= CW'(QUEUE_DEPTH));
    assign st.walk_last = ((idx_reg + CW'(1)) == count_reg);
    assign st.out_free  = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign task_valid     = out_task_valid_reg;
    assign due_task       = out_task_reg;
    assign insert_dropped = out_drop_reg;
    assign entry_count    = out_count_reg;

    `DTEQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(QUEUE_DEPTH), "entry count above depth")
    `DTEQ_ASSERT(a_pop_shrinks, (cmd.pop_check && pop_hit && !st.empty) |=> (count_reg == $past(count_reg) - CW'(1)), "pop did not remove an entry")
    `DTEQ_ASSERT(a_walk_in_range, cmd.walk |-> (idx_reg < count_reg), "walk index past the last entry")

endmodule

`default_nettype wire

### hdl/delta_time_event_queue_top.sv
// Top level of the delta time event queue: controller, datapath and the
// request and result channels. Depends on dteq_pkg, dteq_if, dteq_ctrl,
// dteq_datapath and dteq_ram.
//
// Usage: each request beat on req carries an opcode (insert, advance then
// pop, pop only, clear) with task_id, delay and time_step; every request
// produces exactly one result beat on rsp with task_valid, due_task,
// insert_dropped and entry_count. Entries are kept as a delta list in a
// circular RAM; pops move the head pointer, inserts ripple the entries
// behind the insertion point back by one slot during a single forward walk.
// Each request is decoded; a pop reads and checks the front entry, an
// advance adds the time step first, a clear or dropped insert ends there,
// and an insert walks the entries and writes the tail slot; the RAM read
// port, one entry per cycle, sets the insert time. The next request is
// accepted in the cycle after the result is loaded. Reset empties the queue
// and clears the elapsed counter and output valid flag; no RAM clearing is
// needed. A stalled result stays in the output register; the next request
// is still accepted and worked on, waiting only to load its own result.
`default_nettype none

module delta_time_event_queue_top
    import dteq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dteq_in_if.sink     req,
    dteq_out_if.source  rsp
);

    cmd_t    cmd;
    status_t st;

    dteq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .st       (st),
        .cmd      (cmd)
    );

    dteq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .opcode         (req.opcode),
        .task_id        (req.task_id),
        .delay          (req.delay),
        .time_step      (req.time_step),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .task_valid     (rsp.task_valid),
        .due_task       (rsp.due_task),
        .insert_dropped (rsp.insert_dropped),
        .entry_count    (rsp.entry_count)
    );

endmodule

`default_nettype wire
